[rtl/core/sigma_delta_adc_two_wire_reader_unit_assert.svh]
// Assertion macros shared by the checker of the two-wire converter reader.
// Holds macro definitions only; no dependencies.
`ifndef SIGMA_DELTA_ADC_TWO_WIRE_READER_UNIT_ASSERT_SVH
`define SIGMA_DELTA_ADC_TWO_WIRE_READER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SDR_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SDR_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/sdr_pkg.sv]
// Package of the two-wire converter reader: state codes, commands and helpers.
// No dependencies.
`default_nettype none
package sdr_pkg;
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_SAFE    = 2'd3;

    localparam logic [2:0] ST_DISABLED = 3'd0;
    localparam logic [2:0] ST_POWERUP  = 3'd1;
    localparam logic [2:0] ST_CONFIG   = 3'd2;
    localparam logic [2:0] ST_SETTLE   = 3'd3;
    localparam logic [2:0] ST_RUN      = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] REG_RATE    = 3'd0;
    localparam logic [2:0] REG_GAIN    = 3'd1;
    localparam logic [2:0] REG_CHANNEL = 3'd2;
    localparam logic [2:0] REG_REFOUT  = 3'd3;
    localparam logic [2:0] REG_WAIT    = 3'd4;
    localparam logic [2:0] REG_SETTLE  = 3'd5;

    localparam logic [6:0] CMD_WRITE_CODE = 7'h65;
    localparam logic [6:0] CMD_READ_CODE  = 7'h56;
    localparam logic [7:0] REF_OFF_BIT    = 8'h40;
    localparam logic [5:0] FRAME_CLOCKS   = 6'd27;
    localparam logic [5:0] CFG_CLOCKS     = 6'd46;
    localparam logic [5:0] STATUS_LAST    = 6'd26;

    // One stored sample: value, status bits and timestamp.
    typedef struct packed {
        logic [23:0] value;
        logic [1:0]  status;
        logic [31:0] time_ms;
    } sample_t;

    // Level on the data line for clock r of a configuration transaction.
    function automatic logic line_bit(input logic [5:0] r, input logic [6:0] code,
                                      input logic [7:0] tx);
        logic res;
        if (r < 6'd30)
            res = 1'b1;
        else if (r <= 6'd36)
            res = code[3'(6'd36 - r)];
        else if (r == 6'd37)
            res = code[0];
        else
            res = tx[3'(6'd45 - r)];
        return res;
    endfunction
endpackage
`default_nettype wire

[rtl/core/sdr_fifo.sv]
// Sample FIFO of the converter reader: one synchronous memory, registered read.
// Depends on sdr_pkg for the sample type.
`default_nettype none
module sdr_fifo #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clear,
    input  wire logic                       push,
    input  wire sdr_pkg::sample_t           push_data,
    input  wire logic                       pop,
    output      sdr_pkg::sample_t           pop_data,
    output      logic                       full,
    output      logic                       empty,
    output      logic [$clog2(DEPTH+1)-1:0] count_next_out
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sdr_pkg::sample_t mem [DEPTH];
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
        logic [AW-1:0] res;
        if (p == AW'(DEPTH - 1))
            res = '0;
        else
            res = p + 1'b1;
        return res;
    endfunction

    assign count_next_out = count_next;
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (push)
                tail_next = incr(tail_reg);
            if (pop)
                head_next = incr(head_reg);
            if (push && !pop)
                count_next = count_reg + 1'b1;
            else if (pop && !push)
                count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= push_data;
        pop_data <= mem[head_reg];
    end
endmodule
`default_nettype wire

[rtl/core/sigma_delta_adc_two_wire_reader_unit.sv]
// Top level of the two-wire sigma-delta converter reader.
// Uses sdr_pkg and sdr_fifo.
//
// The input channel (valid/ready) carries one command per transfer: a tick
// (one SCLK half period), a pop, a restart or a safe-state request, with the
// sampled data line and the current millisecond time. Every accepted item
// yields exactly one result transfer on the output channel with the bus
// levels, any popped sample and the status counters.
// Each result is registered in stage 1, then in the output buffer. One item
// is accepted per cycle: the engine state sits in registers, samples in a
// synchronous FIFO memory whose registered read completes the result in stage 1.
// A two-entry output buffer lets input continue while a result waits; ready
// drops only when the buffer cannot take what is in flight.
// After reset the block waits for the first item's time, counts out the
// power-up wait, configures the converter and verifies the read-back. A
// stalled receiver simply holds results in the buffer and stops the input.
// Configuration registers are written through the plain write port.
`default_nettype none
module sigma_delta_adc_two_wire_reader_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic        data_in,
    input  wire logic [31:0] now_ms,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        sclk,
    output      logic        data_out,
    output      logic        data_drive,
    output      logic        pop_valid,
    output      logic signed [23:0] sample_value,
    output      logic [1:0]  sample_status,
    output      logic [31:0] sample_time_ms,
    output      logic [4:0]  buffered_count,
    output      logic [2:0]  ctrl_state,
    output      logic [31:0] overrun_count,
    output      logic [31:0] error_count,
    output      logic [7:0]  last_config_byte
);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        sclk;
        logic        data_out;
        logic        data_drive;
        logic        pop_valid;
        logic [23:0] value;
        logic [1:0]  status;
        logic [31:0] time_ms;
        logic [4:0]  count;
        logic [2:0]  state;
        logic [31:0] overrun;
        logic [31:0] errors;
        logic [7:0]  cfg_byte;
    } result_t;

    // Configuration registers
    logic [1:0]  rate_reg, gain_reg, chan_reg;
    logic        refout_reg;
    logic [15:0] wait_reg;
    logic [7:0]  settle_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= '0;
            gain_reg       <= '0;
            chan_reg       <= '0;
            refout_reg     <= 1'b1;
            wait_reg       <= 16'd100;
            settle_cfg_reg <= 8'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdr_pkg::REG_RATE:    rate_reg       <= cfg_data[1:0];
                sdr_pkg::REG_GAIN:    gain_reg       <= cfg_data[1:0];
                sdr_pkg::REG_CHANNEL: chan_reg       <= cfg_data[1:0];
                sdr_pkg::REG_REFOUT:  refout_reg     <= cfg_data[0];
                sdr_pkg::REG_WAIT:    wait_reg       <= cfg_data;
                sdr_pkg::REG_SETTLE:  settle_cfg_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Engine state
    logic [2:0]  state_reg, state_next;
    logic        verify_reg, verify_next;
    logic [31:0] enter_reg, enter_next;
    logic        taken_reg, taken_next;
    logic [5:0]  pos_reg, pos_next;
    logic        high_reg, high_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  tx_reg, tx_next;
    logic [7:0]  rx_reg, rx_next;
    logic [25:0] shift_reg, shift_next;
    logic [7:0]  settle_reg, settle_next;
    logic [31:0] overrun_reg, overrun_next;
    logic [31:0] error_reg, error_next;
    logic [7:0]  lastcfg_reg, lastcfg_next;

    logic        accept;
    logic        fifo_clear, fifo_push, fifo_pop, fifo_full, fifo_empty;
    sdr_pkg::sample_t push_data, pop_data;
    logic [CW-1:0] fifo_count_next;

    logic        enc_ok;
    logic [7:0]  enc_byte;
    logic [1:0]  ch_bits;
    logic [31:0] now_eff;
    logic [5:0]  r;
    logic        drive_c, dout_c;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        enc_ok  = 1'b1;
        ch_bits = 2'b00;
        case (chan_reg)
            2'd0: ch_bits = 2'b00;
            2'd1: ch_bits = 2'b10;
            2'd2: ch_bits = 2'b11;
            default: enc_ok = 1'b0;
        endcase
        enc_byte = {2'b00, rate_reg, gain_reg, ch_bits};
        if (!refout_reg)
            enc_byte = enc_byte | sdr_pkg::REF_OFF_BIT;
    end

    always_comb
    begin
        state_next   = state_reg;
        verify_next  = verify_reg;
        enter_next   = enter_reg;
        taken_next   = taken_reg;
        pos_next     = pos_reg;
        high_next    = high_reg;
        kind_next    = kind_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        shift_next   = shift_reg;
        settle_next  = settle_reg;
        overrun_next = overrun_reg;
        error_next   = error_reg;
        lastcfg_next = lastcfg_reg;
        fifo_clear   = 1'b0;
        fifo_push    = 1'b0;
        fifo_pop     = 1'b0;
        push_data    = {shift_reg[25:2], shift_reg[1:0], now_ms};
        now_eff      = taken_reg ? enter_reg : now_ms;

        if (accept)
        begin
            if (!taken_reg)
            begin
                enter_next = now_ms;
                taken_next = 1'b1;
            end
            case (cmd)
                sdr_pkg::CMD_TICK:
                begin
                    if (state_reg == sdr_pkg::ST_POWERUP)
                    begin
                        if ((now_ms - now_eff) >= {16'd0, wait_reg})
                        begin
                            verify_next = 1'b0;
                            state_next  = sdr_pkg::ST_CONFIG;
                        end
                    end
                    else if (state_reg == sdr_pkg::ST_DISABLED ||
                             state_reg == sdr_pkg::ST_ERROR)
                    begin
                    end
                    else if (pos_reg != '0)
                    begin
                        if (high_reg)
                        begin
                            high_next = 1'b0;
                            if (pos_reg <= sdr_pkg::STATUS_LAST)
                                shift_next = {shift_reg[24:0], data_in};
                            if (kind_reg == sdr_pkg::KIND_READ && pos_reg >= 6'd38 &&
                                pos_reg <= 6'd45)
                                rx_next = {rx_reg[6:0], data_in};
                            if (kind_reg == sdr_pkg::KIND_FRAME &&
                                pos_reg >= sdr_pkg::FRAME_CLOCKS)
                            begin
                                pos_next = '0;
                                if (state_reg == sdr_pkg::ST_SETTLE)
                                begin
                                    if (settle_reg != '0)
                                        settle_next = settle_reg - 1'b1;
                                    if (settle_reg <= 8'd1)
                                        state_next = sdr_pkg::ST_RUN;
                                end
                                else if (state_reg == sdr_pkg::ST_RUN)
                                begin
                                    if (fifo_full)
                                        overrun_next = overrun_reg + 1'b1;
                                    else
                                        fifo_push = 1'b1;
                                end
                            end
                            else if (kind_reg != sdr_pkg::KIND_FRAME &&
                                     pos_reg >= sdr_pkg::CFG_CLOCKS)
                            begin
                                pos_next = '0;
                                if (kind_reg == sdr_pkg::KIND_WRITE)
                                    verify_next = 1'b1;
                                else
                                begin
                                    lastcfg_next = rx_reg;
                                    if (!enc_ok || enc_byte != rx_reg)
                                    begin
                                        error_next = error_reg + 1'b1;
                                        state_next = sdr_pkg::ST_ERROR;
                                    end
                                    else
                                    begin
                                        settle_next = settle_cfg_reg;
                                        state_next  = sdr_pkg::ST_SETTLE;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            pos_next  = pos_reg + 1'b1;
                            high_next = 1'b1;
                        end
                    end
                    else if (!data_in)
                    begin
                        shift_next = '0;
                        rx_next    = '0;
                        pos_next   = 6'd1;
                        high_next  = 1'b1;
                        if (state_reg == sdr_pkg::ST_CONFIG)
                        begin
                            if (!verify_reg)
                            begin
                                kind_next = sdr_pkg::KIND_WRITE;
                                tx_next   = enc_byte;
                                if (!enc_ok)
                                begin
                                    error_next = error_reg + 1'b1;
                                    state_next = sdr_pkg::ST_ERROR;
                                    pos_next   = '0;
                                    high_next  = 1'b0;
                                end
                            end
                            else
                            begin
                                kind_next = sdr_pkg::KIND_READ;
                                tx_next   = '0;
                            end
                        end
                        else
                            kind_next = sdr_pkg::KIND_FRAME;
                    end
                end
                sdr_pkg::CMD_POP:
                    fifo_pop = !fifo_empty;
                sdr_pkg::CMD_RESTART:
                begin
                    if (state_reg != sdr_pkg::ST_DISABLED)
                    begin
                        pos_next    = '0;
                        high_next   = 1'b0;
                        fifo_clear  = 1'b1;
                        verify_next = 1'b0;
                        state_next  = sdr_pkg::ST_CONFIG;
                    end
                end
                default:
                begin
                    pos_next   = '0;
                    high_next  = 1'b0;
                    state_next = sdr_pkg::ST_DISABLED;
                end
            endcase
        end
    end

    // Bus levels from the updated state
    always_comb
    begin
        drive_c = 1'b0;
        dout_c  = 1'b0;
        r = high_next ? pos_next : pos_next + 1'b1;
        if (pos_next != '0 && kind_next != sdr_pkg::KIND_FRAME)
        begin
            if (r >= 6'd28 &&
                r <= ((kind_next == sdr_pkg::KIND_WRITE) ? 6'd45 : 6'd36))
            begin
                drive_c = 1'b1;
                dout_c  = sdr_pkg::line_bit(r, (kind_next == sdr_pkg::KIND_WRITE) ?
                          sdr_pkg::CMD_WRITE_CODE : sdr_pkg::CMD_READ_CODE, tx_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sdr_pkg::ST_POWERUP;
            verify_reg  <= 1'b0;
            enter_reg   <= '0;
            taken_reg   <= 1'b0;
            pos_reg     <= '0;
            high_reg    <= 1'b0;
            kind_reg    <= sdr_pkg::KIND_FRAME;
            tx_reg      <= '0;
            rx_reg      <= '0;
            shift_reg   <= '0;
            settle_reg  <= '0;
            overrun_reg <= '0;
            error_reg   <= '0;
            lastcfg_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            verify_reg  <= verify_next;
            enter_reg   <= enter_next;
            taken_reg   <= taken_next;
            pos_reg     <= pos_next;
            high_reg    <= high_next;
            kind_reg    <= kind_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            shift_reg   <= shift_next;
            settle_reg  <= settle_next;
            overrun_reg <= overrun_next;
            error_reg   <= error_next;
            lastcfg_reg <= lastcfg_next;
        end
    end

    sdr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (fifo_clear),
        .push           (fifo_push),
        .push_data      (push_data),
        .pop            (fifo_pop),
        .pop_data       (pop_data),
        .full           (fifo_full),
        .empty          (fifo_empty),
        .count_next_out (fifo_count_next)
    );

    // Stage 1: result without the sample, waiting for the memory read.
    result_t s1_reg;
    logic    s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.sclk       <= (pos_next != '0) && high_next;
            s1_reg.data_out   <= dout_c;
            s1_reg.data_drive <= drive_c;
            s1_reg.pop_valid  <= fifo_pop;
            s1_reg.value      <= '0;
            s1_reg.status     <= '0;
            s1_reg.time_ms    <= '0;
            s1_reg.count      <= 5'(fifo_count_next);
            s1_reg.state      <= state_next;
            s1_reg.overrun    <= overrun_next;
            s1_reg.errors     <= error_next;
            s1_reg.cfg_byte   <= lastcfg_next;
        end
    end

    result_t s1_full;
    always_comb
    begin
        s1_full = s1_reg;
        if (s1_reg.pop_valid)
        begin
            s1_full.value   = pop_data.value;
            s1_full.status  = pop_data.status;
            s1_full.time_ms = pop_data.time_ms;
        end
    end

    // Two-entry output buffer
    result_t     buf_reg [2];
    logic        rd_ptr_reg, wr_ptr_reg;
    logic [1:0]  occ_reg;
    logic        deq;

    assign out_valid = (occ_reg != 2'd0);
    assign deq = out_valid && out_ready;
    // Room needed for the item in stage 1 plus a new one.
    assign in_ready = ({1'b0, occ_reg} + {2'b00, s1_valid_reg}) <= 3'd1 ||
                      (deq && ({1'b0, occ_reg} + {2'b00, s1_valid_reg}) <= 3'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            occ_reg    <= '0;
        end
        else
        begin
            if (s1_valid_reg)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (deq)
                rd_ptr_reg <= ~rd_ptr_reg;
            occ_reg <= occ_reg + {1'b0, s1_valid_reg} - {1'b0, deq};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            buf_reg[wr_ptr_reg] <= s1_full;
    end

    result_t head;
    assign head = buf_reg[rd_ptr_reg];
    assign sclk             = head.sclk;
    assign data_out         = head.data_out;
    assign data_drive       = head.data_drive;
    assign pop_valid        = head.pop_valid;
    assign sample_value     = head.value;
    assign sample_status    = head.status;
    assign sample_time_ms   = head.time_ms;
    assign buffered_count   = head.count;
    assign ctrl_state       = head.state;
    assign overrun_count    = head.overrun;
    assign error_count      = head.errors;
    assign last_config_byte = head.cfg_byte;
endmodule
`default_nettype wire

[rtl/core/sdr_checker.sv]
// Port-level checker of the two-wire converter reader, bound to the top level.
// Depends on sdr_pkg and the assertion macro header.
`default_nettype none
`include "sigma_delta_adc_two_wire_reader_unit_assert.svh"
module sdr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        data_out,
    input wire logic        data_drive,
    input wire logic        pop_valid,
    input wire logic [23:0] sample_value,
    input wire logic [2:0]  ctrl_state,
    input wire logic [7:0]  last_config_byte
);
    `SDR_ASSERT_IMP(a_dout_released, clk, rst_n, out_valid && !data_drive, !data_out)
    `SDR_ASSERT_IMP(a_no_pop_value, clk, rst_n, out_valid && !pop_valid, sample_value == '0)
    `SDR_ASSERT_IMP(a_state_range, clk, rst_n, out_valid, ctrl_state <= sdr_pkg::ST_ERROR)
    `SDR_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(last_config_byte))
endmodule

bind sigma_delta_adc_two_wire_reader_unit sdr_checker u_sdr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_out         (data_out),
    .data_drive       (data_drive),
    .pop_valid        (pop_valid),
    .sample_value     (sample_value),
    .ctrl_state       (ctrl_state),
    .last_config_byte (last_config_byte)
);
`default_nettype wire

[sim/sigma_delta_adc_two_wire_reader_unit_tb.sv]
// Self-checking testbench of the two-wire sigma-delta converter reader.
// A scoreboard class predicts one result per accepted command; depends on sdr_pkg and the RTL.
`timescale 1ns / 1ps
module sigma_delta_adc_two_wire_reader_unit_tb;
    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        sclk;
        logic        data_out;
        logic        data_drive;
        logic        pop_valid;
        logic [23:0] sample_value;
        logic [1:0]  sample_status;
        logic [31:0] sample_time_ms;
        logic [4:0]  buffered_count;
        logic [2:0]  ctrl_state;
        logic [31:0] overrun_count;
        logic [31:0] error_count;
        logic [7:0]  last_config_byte;
    } reader_result_t;

    class sdr_scoreboard;
        logic [1:0]  rate, gain, chan;
        logic        ref_on;
        logic [15:0] wait_ms;
        logic [7:0]  settle_cfg;
        logic [2:0]  ctrl;
        logic        verify, taken, high;
        logic [31:0] enter_t;
        int          pos;
        logic [1:0]  kind;
        logic [7:0]  tx, rx, lcb, settle_left;
        logic [25:0] shift;
        sdr_pkg::sample_t store [DEPTH];
        int          head, tail, cnt;
        logic [31:0] overruns, errors;
        reader_result_t pending[$];
        int          fails;

        function new();
            rate = 0; gain = 0; chan = 0; ref_on = 1; wait_ms = 100; settle_cfg = 4;
            ctrl = sdr_pkg::ST_POWERUP; verify = 0; taken = 0; high = 0; enter_t = 0;
            pos = 0; kind = sdr_pkg::KIND_FRAME; tx = 0; rx = 0; lcb = 0; settle_left = 0;
            shift = 0; head = 0; tail = 0; cnt = 0; overruns = 0; errors = 0; fails = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                sdr_pkg::REG_RATE:    rate = v[1:0];
                sdr_pkg::REG_GAIN:    gain = v[1:0];
                sdr_pkg::REG_CHANNEL: chan = v[1:0];
                sdr_pkg::REG_REFOUT:  ref_on = v[0];
                sdr_pkg::REG_WAIT:    wait_ms = v;
                sdr_pkg::REG_SETTLE:  settle_cfg = v[7:0];
                default: ;
            endcase
        endfunction

        // Config byte for the current settings; the fourth channel code has none.
        function bit config_byte(output logic [7:0] b);
            logic [1:0] ch;
            case (chan)
                2'd0: ch = 2'b00;
                2'd1: ch = 2'b10;
                2'd2: ch = 2'b11;
                default: return 0;
            endcase
            b = {1'b0, ~ref_on, rate, gain, ch};
            return 1;
        endfunction

        function void frame_done(logic [31:0] now);
            if (ctrl == sdr_pkg::ST_SETTLE) begin
                if (settle_left != 0) settle_left--;
                if (settle_left == 0) ctrl = sdr_pkg::ST_RUN;
            end
            else if (ctrl == sdr_pkg::ST_RUN) begin
                if (cnt >= DEPTH) overruns++;
                else
                begin
                    store[tail] = '{value: shift[25:2], status: shift[1:0], time_ms: now};
                    tail = (tail + 1) % DEPTH;
                    cnt++;
                end
            end
        endfunction

        function void config_done();
            logic [7:0] want;
            if (kind == sdr_pkg::KIND_WRITE) begin
                verify = 1;
                return;
            end
            lcb = rx;
            if (!config_byte(want) || want != lcb) begin
                errors++;
                ctrl = sdr_pkg::ST_ERROR;
                return;
            end
            settle_left = settle_cfg;
            ctrl = sdr_pkg::ST_SETTLE;
        endfunction

        function void tick(logic din, logic [31:0] now);
            logic [7:0] b;
            if (ctrl == sdr_pkg::ST_DISABLED || ctrl == sdr_pkg::ST_ERROR) return;
            if (ctrl == sdr_pkg::ST_POWERUP) begin
                if (now - enter_t >= {16'd0, wait_ms}) begin
                    verify = 0;
                    ctrl = sdr_pkg::ST_CONFIG;
                end
                return;
            end
            if (pos != 0) begin
                if (high) begin
                    if (pos <= 26) shift = {shift[24:0], din};
                    if (kind == sdr_pkg::KIND_READ && pos >= 38 && pos <= 45)
                        rx = {rx[6:0], din};
                    high = 0;
                    if (kind == sdr_pkg::KIND_FRAME && pos >= sdr_pkg::FRAME_CLOCKS) begin
                        pos = 0;
                        frame_done(now);
                    end
                    else if (kind != sdr_pkg::KIND_FRAME && pos >= sdr_pkg::CFG_CLOCKS) begin
                        pos = 0;
                        config_done();
                    end
                end
                else
                begin
                    pos++;
                    high = 1;
                end
                return;
            end
            if (din) return;
            shift = 0;
            rx = 0;
            if (ctrl == sdr_pkg::ST_CONFIG) begin
                if (!verify) begin
                    if (!config_byte(b)) begin
                        errors++;
                        ctrl = sdr_pkg::ST_ERROR;
                        return;
                    end
                    kind = sdr_pkg::KIND_WRITE;
                    tx = b;
                end
                else
                begin
                    kind = sdr_pkg::KIND_READ;
                    tx = 0;
                end
            end
            else kind = sdr_pkg::KIND_FRAME;
            pos = 1;
            high = 1;
        endfunction

        function void note_input(logic [1:0] c, logic din, logic [31:0] now);
            reader_result_t e;
            int r;
            logic [6:0] code;
            e = '{default: '0};
            if (!taken) begin
                enter_t = now;
                taken = 1;
            end
            case (c)
                sdr_pkg::CMD_TICK: tick(din, now);
                sdr_pkg::CMD_POP:
                    if (cnt > 0) begin
                        e.pop_valid = 1;
                        e.sample_value = store[head].value;
                        e.sample_status = store[head].status;
                        e.sample_time_ms = store[head].time_ms;
                        head = (head + 1) % DEPTH;
                        cnt--;
                    end
                sdr_pkg::CMD_RESTART:
                    if (ctrl != sdr_pkg::ST_DISABLED) begin
                        pos = 0; high = 0;
                        head = 0; tail = 0; cnt = 0;
                        verify = 0;
                        ctrl = sdr_pkg::ST_CONFIG;
                    end
                default:
                begin
                    pos = 0; high = 0;
                    ctrl = sdr_pkg::ST_DISABLED;
                end
            endcase
            if (pos != 0 && kind != sdr_pkg::KIND_FRAME) begin
                r = high ? pos : pos + 1;
                code = (kind == sdr_pkg::KIND_WRITE) ? sdr_pkg::CMD_WRITE_CODE
                                                     : sdr_pkg::CMD_READ_CODE;
                if (r >= 28 && r <= (kind == sdr_pkg::KIND_WRITE ? 45 : 36)) begin
                    e.data_drive = 1;
                    if (r < 30) e.data_out = 1;
                    else if (r <= 36) e.data_out = code[36 - r];
                    else if (r == 37) e.data_out = code[0];
                    else e.data_out = tx[45 - r];
                end
            end
            e.sclk = (pos != 0) && high;
            e.buffered_count = cnt[4:0];
            e.ctrl_state = ctrl;
            e.overrun_count = overruns;
            e.error_count = errors;
            e.last_config_byte = lcb;
            pending.push_back(e);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(reader_result_t g);
            reader_result_t e;
            if (pending.size() == 0) begin
                $error("result transfer with no command outstanding");
                fails++;
                return;
            end
            e = pending.pop_front();
            compare("sclk", e.sclk, g.sclk);
            compare("data_out", e.data_out, g.data_out);
            compare("data_drive", e.data_drive, g.data_drive);
            compare("pop_valid", e.pop_valid, g.pop_valid);
            compare("sample_value", e.sample_value, g.sample_value);
            compare("sample_status", e.sample_status, g.sample_status);
            compare("sample_time_ms", e.sample_time_ms, g.sample_time_ms);
            compare("buffered_count", e.buffered_count, g.buffered_count);
            compare("ctrl_state", e.ctrl_state, g.ctrl_state);
            compare("overrun_count", e.overrun_count, g.overrun_count);
            compare("error_count", e.error_count, g.error_count);
            compare("last_config_byte", e.last_config_byte, g.last_config_byte);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  cmd = sdr_pkg::CMD_TICK;
    logic        data_in = 0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        sclk, data_out, data_drive, pop_valid;
    logic signed [23:0] sample_value;
    logic [1:0]  sample_status;
    logic [31:0] sample_time_ms;
    logic [4:0]  buffered_count;
    logic [2:0]  ctrl_state;
    logic [31:0] overrun_count, error_count;
    logic [7:0]  last_config_byte;

    sdr_scoreboard sb = new();
    bit          quiet = 0;
    logic [31:0] clock_ms;
    int          cycles = 0;
    int          ready_hold = 0;

    sigma_delta_adc_two_wire_reader_unit #(.FIFO_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .data_in(data_in), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .sclk(sclk), .data_out(data_out), .data_drive(data_drive),
        .pop_valid(pop_valid), .sample_value(sample_value),
        .sample_status(sample_status), .sample_time_ms(sample_time_ms),
        .buffered_count(buffered_count), .ctrl_state(ctrl_state),
        .overrun_count(overrun_count), .error_count(error_count),
        .last_config_byte(last_config_byte)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random bursts of readiness and stall, always ready when quiet.
    always @(posedge clk)
    begin
        if (quiet) out_ready <= 1;
        else if (ready_hold > 0) ready_hold--;
        else
        begin
            out_ready <= ($urandom_range(0, 2) != 0);
            ready_hold = $urandom_range(1, 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{sclk, data_out, data_drive, pop_valid, sample_value,
                              sample_status, sample_time_ms, buffered_count, ctrl_state,
                              overrun_count, error_count, last_config_byte});
    end

    task automatic send(logic [1:0] c, logic d, logic [31:0] t);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        data_in <= d;
        now_ms <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(c, d, t);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller releases it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic write_all(logic [1:0] r, logic [1:0] g, logic [1:0] ch, logic refo,
                             logic [15:0] w, logic [7:0] s);
        write_reg(sdr_pkg::REG_RATE, r);
        write_reg(sdr_pkg::REG_GAIN, g);
        write_reg(sdr_pkg::REG_CHANNEL, ch);
        write_reg(sdr_pkg::REG_REFOUT, refo);
        write_reg(sdr_pkg::REG_WAIT, w);
        write_reg(sdr_pkg::REG_SETTLE, s);
        cfg_we <= 0;
    endtask

    // Line level for the next tick: mostly starts transactions promptly and
    // answers the read-back correctly, with occasional wrong bits.
    function automatic logic pick_line();
        logic [7:0] want;
        if (sb.pos == 0) return ($urandom_range(0, 3) == 0);
        if (sb.kind == sdr_pkg::KIND_READ && sb.high && sb.pos >= 38 && sb.pos <= 45
            && sb.config_byte(want) && $urandom_range(0, 29) != 0)
            return want[45 - sb.pos];
        return $urandom_range(0, 1);
    endfunction

    task automatic run_traffic(int n, int pop_permille);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 999);
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(0, 3);
            if (r < 4 || (sb.ctrl == sdr_pkg::ST_ERROR && r < 60))
                send(sdr_pkg::CMD_RESTART, $urandom_range(0, 1), clock_ms);
            else if (r < 4 + pop_permille)
                send(sdr_pkg::CMD_POP, $urandom_range(0, 1), clock_ms);
            else
                send(sdr_pkg::CMD_TICK, pick_line(), clock_ms);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Short power-up wait whose time window wraps through zero.
        write_all(2'd3, 2'd3, 2'd2, 1'b0, 16'd20, 8'd0);
        clock_ms = 32'hFFFF_FFF0;
        send(sdr_pkg::CMD_POP, 1'b1, clock_ms);
        while (sb.ctrl == sdr_pkg::ST_POWERUP) begin
            clock_ms++;
            send(sdr_pkg::CMD_TICK, 1'b0, clock_ms);
        end
        send(sdr_pkg::CMD_TICK, 1'b1, clock_ms);
        send(sdr_pkg::CMD_POP, 1'b0, clock_ms);
        send(sdr_pkg::CMD_RESTART, 1'b0, clock_ms);
        run_traffic(350, 110);
        drain();

        write_all(2'd0, 2'd0, 2'd0, 1'b1, 16'hFFFF, 8'd255);
        send(sdr_pkg::CMD_RESTART, 1'b0, clock_ms);
        run_traffic(200, 100);
        drain();

        // The unused channel code makes configuration fail.
        write_all(2'd1, 2'd2, 2'd3, 1'b1, 16'd0, 8'd1);
        send(sdr_pkg::CMD_RESTART, 1'b0, clock_ms);
        run_traffic(60, 20);
        drain();

        // Few pops so that samples accumulate in the store.
        write_all(2'd2, 2'd1, 2'd1, 1'b0, 16'd100, 8'd4);
        send(sdr_pkg::CMD_RESTART, 1'b0, clock_ms);
        run_traffic(250, 5);
        drain();
        run_traffic(150, 150);
        drain();

        write_all(2'd1, 2'd0, 2'd0, 1'b1, 16'd7, 8'd2);
        quiet = 1;
        send(sdr_pkg::CMD_RESTART, 1'b0, clock_ms);
        run_traffic(400, 100);
        send(sdr_pkg::CMD_SAFE, 1'b1, clock_ms);
        send(sdr_pkg::CMD_RESTART, 1'b0, clock_ms);
        run_traffic(20, 300);
        drain();

        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
